// ===== hw/rtl/mecc_pkg.sv =====
// mecc_pkg: shared widths, constants, payload and control types for the
// edge membership check block. No dependencies.
package mecc_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_GROUP_DEF = 256;

    localparam int NODE_W     = 10;
    localparam int WEIGHT_W   = 32;
    localparam int ID_W       = 16;
    localparam int NCOUNT_W   = 11;
    // wide enough for any node count limit up to the largest node parameter
    localparam int CMP_W      = 17;
    localparam int RANK_W     = 4;
    localparam int RANK_MAX   = 15;
    localparam int NCOUNT_RST = 1024;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    // register index taken from the word address bit
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_CHECK = 2'd1,
        OP_JOIN  = 2'd2
    } uf_op_t;

    typedef struct packed {
        logic   start;
        uf_op_t op;
    } uf_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic differ;
    } uf_stat_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [ID_W-1:0]     edge_id;
        logic                first_of_graph;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] result_edge_id;
        logic            in_some_tree;
        logic            weight_order_error;
        logic            group_overflow;
    } out_item_t;

endpackage

// ===== hw/rtl/mecc_stream_if.sv =====
// mecc_stream_if: valid/ready channel carrying one payload item.
// Payload type is given by the instantiating level (see mecc_pkg).
interface mecc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mecc_cfg.sv =====
// mecc_cfg: APB-style register port holding node_count and the derived
// node limit. Depends on mecc_pkg.
module mecc_cfg #(
    parameter int MAX_NODES = mecc_pkg::MAX_NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mecc_pkg::PADDR_W-1:0]  paddr,
    input  logic [mecc_pkg::PDATA_W-1:0]  pwdata,
    output logic [mecc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [mecc_pkg::CMP_W-1:0]    node_limit
);

    logic [mecc_pkg::NCOUNT_W-1:0] node_count_reg;
    logic [mecc_pkg::CMP_W-1:0]    nc_ext;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == mecc_pkg::REG_NODE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= mecc_pkg::NCOUNT_W'(mecc_pkg::NCOUNT_RST);
        end
        else if (wr_en)
        begin
            node_count_reg <= pwdata[mecc_pkg::NCOUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == mecc_pkg::REG_NODE_COUNT) ?
                    mecc_pkg::PDATA_W'(node_count_reg) : '0;

    // clamp to the forest size, zero acts as one
    always_comb
    begin
        nc_ext = mecc_pkg::CMP_W'(node_count_reg);
        if (nc_ext > mecc_pkg::CMP_W'(MAX_NODES))
        begin
            node_limit = mecc_pkg::CMP_W'(MAX_NODES);
        end
        else if (nc_ext == '0)
        begin
            node_limit = mecc_pkg::CMP_W'(1);
        end
        else
        begin
            node_limit = nc_ext;
        end
    end

endmodule

// ===== hw/rtl/mecc_forest.sv =====
// mecc_forest: union-find forest in one synchronous memory ({parent, rank}
// per node) with its find / compress / link engine and clearing sweep.
// Depends on mecc_pkg.
module mecc_forest #(
    parameter int MAX_NODES = mecc_pkg::MAX_NODES_DEF,
    localparam int NW = $clog2(MAX_NODES),
    localparam int MW = NW + mecc_pkg::RANK_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mecc_pkg::uf_cmd_t cmd,
    input  logic [NW-1:0]     cmd_a,
    input  logic [NW-1:0]     cmd_b,
    output mecc_pkg::uf_stat_t stat
);

    typedef enum logic [5:0] {
        E_IDLE = 6'b000001,
        E_CLR  = 6'b000010,
        E_WALK = 6'b000100,
        E_COMP = 6'b001000,
        E_LINK = 6'b010000,
        E_BUMP = 6'b100000
    } eng_state_t;

    logic [MW-1:0] mem [MAX_NODES];
    logic [MW-1:0] rd_data_reg;
    logic          we;
    logic [NW-1:0] wa, ra;
    logic [MW-1:0] wd;

    eng_state_t state_reg, state_next;
    mecc_pkg::uf_op_t op_reg, op_next;
    logic                       phase_reg, phase_next;
    logic [NW-1:0]              start_reg, start_next;
    logic [NW-1:0]              cur_reg, cur_next;
    logic [NW-1:0]              b_reg, b_next;
    logic [NW-1:0]              root_reg, root_next;
    logic [mecc_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic [NW-1:0]              ra_reg, ra_next;
    logic [mecc_pkg::RANK_W-1:0] rka_reg, rka_next;
    logic [NW-1:0]              lo_reg, lo_next, hi_reg, hi_next;
    logic [mecc_pkg::RANK_W-1:0] lo_rank_reg, lo_rank_next, hi_rank_reg, hi_rank_next;
    logic [NW-1:0]              clr_reg, clr_next;
    logic                       differ_reg, differ_next;
    logic                       done;

    logic [NW-1:0]              rd_parent;
    logic [mecc_pkg::RANK_W-1:0] rd_rank;
    logic                       fin;
    logic [NW-1:0]              f_root;
    logic [mecc_pkg::RANK_W-1:0] f_rank;

    assign rd_parent = rd_data_reg[MW-1:mecc_pkg::RANK_W];
    assign rd_rank   = rd_data_reg[mecc_pkg::RANK_W-1:0];

    // write-first forwarding on a same-entry read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= (we && (wa == ra)) ? wd : mem[ra];
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        phase_next   = phase_reg;
        start_next   = start_reg;
        cur_next     = cur_reg;
        b_next       = b_reg;
        root_next    = root_reg;
        rank_next    = rank_reg;
        ra_next      = ra_reg;
        rka_next     = rka_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        lo_rank_next = lo_rank_reg;
        hi_rank_next = hi_rank_reg;
        clr_next     = clr_reg;
        differ_next  = differ_reg;
        done         = 1'b0;
        we           = 1'b0;
        wa           = cur_reg;
        wd           = '0;
        ra           = cur_reg;
        fin          = 1'b0;
        f_root       = root_reg;
        f_rank       = rank_reg;

        unique case (state_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next = cmd.op;
                    if (cmd.op == mecc_pkg::OP_CLEAR)
                    begin
                        clr_next   = '0;
                        state_next = E_CLR;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        start_next = cmd_a;
                        cur_next   = cmd_a;
                        b_next     = cmd_b;
                        ra         = cmd_a;
                        state_next = E_WALK;
                    end
                end
            end
            E_CLR:
            begin
                we = 1'b1;
                wa = clr_reg;
                wd = {clr_reg, mecc_pkg::RANK_W'(0)};
                if (clr_reg == NW'(MAX_NODES - 1))
                begin
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NW'(1);
                end
            end
            E_WALK:
            begin
                if (rd_parent == cur_reg)
                begin
                    root_next = cur_reg;
                    rank_next = rd_rank;
                    f_root    = cur_reg;
                    f_rank    = rd_rank;
                    if (start_reg != cur_reg)
                    begin
                        cur_next   = start_reg;
                        ra         = start_reg;
                        state_next = E_COMP;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    cur_next = rd_parent;
                    ra       = rd_parent;
                end
            end
            E_COMP:
            begin
                // point this node at the root, keep its rank
                we = 1'b1;
                wa = cur_reg;
                wd = {root_reg, rd_rank};
                if (rd_parent == root_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    cur_next = rd_parent;
                    ra       = rd_parent;
                end
            end
            E_LINK:
            begin
                we = 1'b1;
                wa = lo_reg;
                wd = {hi_reg, lo_rank_reg};
                if ((hi_rank_reg == lo_rank_reg) &&
                    (hi_rank_reg < mecc_pkg::RANK_W'(mecc_pkg::RANK_MAX)))
                begin
                    state_next = E_BUMP;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
            end
            E_BUMP:
            begin
                we         = 1'b1;
                wa         = hi_reg;
                wd         = {hi_reg, hi_rank_reg + mecc_pkg::RANK_W'(1)};
                done       = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        // one root walk finished: start the second or conclude
        if (fin)
        begin
            if (!phase_reg)
            begin
                ra_next    = f_root;
                rka_next   = f_rank;
                phase_next = 1'b1;
                start_next = b_reg;
                cur_next   = b_reg;
                ra         = b_reg;
                state_next = E_WALK;
            end
            else if ((op_reg != mecc_pkg::OP_JOIN) || (ra_reg == f_root))
            begin
                differ_next = (ra_reg != f_root);
                done        = 1'b1;
                state_next  = E_IDLE;
            end
            else
            begin
                if (rka_reg < f_rank)
                begin
                    hi_next = f_root;  hi_rank_next = f_rank;
                    lo_next = ra_reg;  lo_rank_next = rka_reg;
                end
                else
                begin
                    hi_next = ra_reg;  hi_rank_next = rka_reg;
                    lo_next = f_root;  lo_rank_next = f_rank;
                end
                state_next = E_LINK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_CLR;
            clr_reg    <= '0;
            op_reg     <= mecc_pkg::OP_CLEAR;
            phase_reg  <= 1'b0;
            differ_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            op_reg     <= op_next;
            phase_reg  <= phase_next;
            differ_reg <= differ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        cur_reg     <= cur_next;
        b_reg       <= b_next;
        root_reg    <= root_next;
        rank_reg    <= rank_next;
        ra_reg      <= ra_next;
        rka_reg     <= rka_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        lo_rank_reg <= lo_rank_next;
        hi_rank_reg <= hi_rank_next;
    end

    assign stat.idle   = (state_reg == E_IDLE);
    assign stat.done   = done;
    assign stat.differ = differ_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_BUMP) |-> ($past(state_reg) == E_LINK))
        else $error("rank bump without a link");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_COMP) |-> (cur_reg != root_reg))
        else $error("compressing the root itself");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && (state_reg != E_IDLE)) |-> 1'b0)
        else $error("command while engine busy");

endmodule

// ===== hw/rtl/mst_edge_membership_check_core.sv =====
// mst_edge_membership_check_core: top level, edge sequencer, weight-group
// state and the pending union buffer memory. Depends on mecc_pkg,
// mecc_stream_if, mecc_cfg and mecc_forest.
// After reset and on every first_of_graph request the forest memory is swept
//   with input held off (register writes still taken).
// Per request: the two root walks, each step a forest memory read, plus path
//   compression rewriting each node on the way; a request that closes a weight
//   group first applies each buffered union, with its two walks each. All of this
//   uses the one forest memory and its engine; one request at a time.
module mst_edge_membership_check_core #(
    parameter int MAX_NODES = mecc_pkg::MAX_NODES_DEF,
    parameter int MAX_GROUP = mecc_pkg::MAX_GROUP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mecc_stream_if.sink                   in_ch,
    mecc_stream_if.source                 out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mecc_pkg::PADDR_W-1:0]  paddr,
    input  logic [mecc_pkg::PDATA_W-1:0]  pwdata,
    output logic [mecc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int GW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNTW = $clog2(MAX_GROUP + 1);

    typedef enum logic [8:0] {
        T_IDLE  = 9'b000000001,
        T_CLR   = 9'b000000010,
        T_DEC   = 9'b000000100,
        T_CHK   = 9'b000001000,
        T_PRD   = 9'b000010000,
        T_PJOIN = 9'b000100000,
        T_PWAIT = 9'b001000000,
        T_CWAIT = 9'b010000000,
        T_FIN   = 9'b100000000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [mecc_pkg::CMP_W-1:0]    node_limit;
    mecc_pkg::uf_cmd_t             eng_cmd;
    mecc_pkg::uf_stat_t            eng_stat;
    logic [NW-1:0]                 eng_a, eng_b;

    logic [2*NW-1:0] pend_mem [MAX_GROUP];
    logic [2*NW-1:0] pend_rd_reg;
    logic            pend_we;

    logic [mecc_pkg::NODE_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [mecc_pkg::WEIGHT_W-1:0] w_reg, w_next, gw_reg, gw_next;
    logic [mecc_pkg::ID_W-1:0]     id_reg, id_next;
    logic                          inr_reg, inr_next;
    logic                          err_reg, err_next;
    logic                          ovf_reg, ovf_next;
    logic                          open_reg, open_next;
    logic [CNTW-1:0]               cnt_reg, cnt_next, k_reg, k_next;
    logic                          out_v_reg, out_v_next;
    mecc_pkg::out_item_t           out_reg, out_next;
    logic                          in_fire, in_range;

    mecc_cfg #(.MAX_NODES(MAX_NODES)) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_limit (node_limit)
    );

    mecc_forest #(.MAX_NODES(MAX_NODES)) u_forest (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (eng_cmd),
        .cmd_a (eng_a),
        .cmd_b (eng_b),
        .stat  (eng_stat)
    );

    assign in_ch.ready = (state_reg == T_IDLE) && eng_stat.idle;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_range    = (mecc_pkg::CMP_W'(in_ch.payload.node_a) < node_limit) &&
                         (mecc_pkg::CMP_W'(in_ch.payload.node_b) < node_limit);

    assign pend_we = (state_reg == T_CWAIT) && eng_stat.done &&
                     (cnt_reg < CNTW'(MAX_GROUP));

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[cnt_reg[GW-1:0]] <= {NW'(a_reg), NW'(b_reg)};
        end
        pend_rd_reg <= pend_mem[k_reg[GW-1:0]];
    end

    assign eng_a = (state_reg == T_PJOIN) ? pend_rd_reg[2*NW-1:NW] : NW'(a_reg);
    assign eng_b = (state_reg == T_PJOIN) ? pend_rd_reg[NW-1:0]    : NW'(b_reg);

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        w_next        = w_reg;
        id_next       = id_reg;
        inr_next      = inr_reg;
        err_next      = err_reg;
        ovf_next      = ovf_reg;
        gw_next       = gw_reg;
        open_next     = open_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg && !out_ch.ready;
        eng_cmd.start = 1'b0;
        eng_cmd.op    = mecc_pkg::OP_CHECK;

        unique case (state_reg)
            T_IDLE:
            begin
                if (in_fire)
                begin
                    a_next   = in_ch.payload.node_a;
                    b_next   = in_ch.payload.node_b;
                    w_next   = in_ch.payload.edge_weight;
                    id_next  = in_ch.payload.edge_id;
                    inr_next = in_range;
                    err_next = 1'b0;
                    ovf_next = 1'b0;
                    if (in_ch.payload.first_of_graph)
                    begin
                        cnt_next      = '0;
                        open_next     = 1'b0;
                        gw_next       = '0;
                        eng_cmd.start = 1'b1;
                        eng_cmd.op    = mecc_pkg::OP_CLEAR;
                        state_next    = T_CLR;
                    end
                    else
                    begin
                        state_next = T_DEC;
                    end
                end
            end
            T_CLR:
            begin
                if (eng_stat.done)
                begin
                    state_next = T_DEC;
                end
            end
            T_DEC:
            begin
                priority if (!open_reg)
                begin
                    open_next  = 1'b1;
                    gw_next    = w_reg;
                    state_next = T_CHK;
                end
                else if (w_reg > gw_reg)
                begin
                    if (cnt_reg == '0)
                    begin
                        gw_next    = w_reg;
                        state_next = T_CHK;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = T_PRD;
                    end
                end
                else if (w_reg < gw_reg)
                begin
                    err_next   = 1'b1;
                    state_next = T_CHK;
                end
                else
                begin
                    state_next = T_CHK;
                end
            end
            T_PRD:
            begin
                state_next = T_PJOIN;
            end
            T_PJOIN:
            begin
                eng_cmd.start = 1'b1;
                eng_cmd.op    = mecc_pkg::OP_JOIN;
                state_next    = T_PWAIT;
            end
            T_PWAIT:
            begin
                if (eng_stat.done)
                begin
                    if ((k_reg + CNTW'(1)) == cnt_reg)
                    begin
                        cnt_next   = '0;
                        gw_next    = w_reg;
                        state_next = T_CHK;
                    end
                    else
                    begin
                        k_next     = k_reg + CNTW'(1);
                        state_next = T_PRD;
                    end
                end
            end
            T_CHK:
            begin
                if (inr_reg)
                begin
                    eng_cmd.start = 1'b1;
                    eng_cmd.op    = mecc_pkg::OP_CHECK;
                    state_next    = T_CWAIT;
                end
                else
                begin
                    state_next = T_FIN;
                end
            end
            T_CWAIT:
            begin
                if (eng_stat.done)
                begin
                    if (cnt_reg < CNTW'(MAX_GROUP))
                    begin
                        cnt_next = cnt_reg + CNTW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = T_FIN;
                end
            end
            T_FIN:
            begin
                if (!out_v_reg || out_ch.ready)
                begin
                    out_next.result_edge_id     = id_reg;
                    out_next.in_some_tree       = inr_reg && eng_stat.differ;
                    out_next.weight_order_error = err_reg;
                    out_next.group_overflow     = ovf_reg;
                    out_v_next                  = 1'b1;
                    state_next                  = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            gw_reg    <= '0;
            open_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            gw_reg    <= gw_next;
            open_reg  <= open_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        w_reg   <= w_next;
        id_reg  <= id_next;
        inr_reg <= inr_next;
        err_reg <= err_next;
        ovf_reg <= ovf_next;
        out_reg <= out_next;
    end

    assign out_ch.valid   = out_v_reg;
    assign out_ch.payload = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_GROUP))
        else $error("pending count past buffer size");

    assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (cnt_reg == '0))
        else $error("buffered unions with no open group");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.payload.first_of_graph) |=> (state_reg == T_CLR))
        else $error("clear request did not start a sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_PJOIN) |-> (k_reg < cnt_reg))
        else $error("union applied beyond buffered entries");

endmodule

// ===== tb/sv/mst_edge_membership_check_core_tb.sv =====
`timescale 1ns / 100ps
// mst_edge_membership_check_core_tb: self-checking bench for the MST edge membership block.
// Drives edges in mostly sorted weight groups, writes node_count over APB; results are checked
// against an in-bench union-find predictor. Depends on mecc_pkg, mecc_stream_if and the core.
module mst_edge_membership_check_core_tb;

    class edge_mst_scoreboard;
        logic [mecc_pkg::NODE_W-1:0]   parent [mecc_pkg::MAX_NODES_DEF];
        logic [mecc_pkg::RANK_W-1:0]   rank_of [mecc_pkg::MAX_NODES_DEF];
        logic [mecc_pkg::NODE_W-1:0]   pend_a[$];
        logic [mecc_pkg::NODE_W-1:0]   pend_b[$];
        logic [mecc_pkg::WEIGHT_W-1:0] group_weight;
        bit                            group_open;
        int unsigned                   node_limit;
        mecc_pkg::out_item_t           answers_due[$];
        int                            mismatches;

        function void clear_forest();
            for (int i = 0; i < mecc_pkg::MAX_NODES_DEF; i++)
            begin
                parent[i]  = mecc_pkg::NODE_W'(i);
                rank_of[i] = '0;
            end
            pend_a.delete();
            pend_b.delete();
            group_open   = 0;
            group_weight = '0;
        endfunction

        function void set_node_count(logic [mecc_pkg::NCOUNT_W-1:0] v);
            if (v > mecc_pkg::MAX_NODES_DEF)
                node_limit = mecc_pkg::MAX_NODES_DEF;
            else if (v == 0)
                node_limit = 1;
            else
                node_limit = v;
        endfunction

        // walk to the root, then point every node on the path at it
        function logic [mecc_pkg::NODE_W-1:0] find_root(logic [mecc_pkg::NODE_W-1:0] v);
            logic [mecc_pkg::NODE_W-1:0] r;
            logic [mecc_pkg::NODE_W-1:0] nxt;
            r = v;
            while (parent[r] != r)
                r = parent[r];
            while (v != r)
            begin
                nxt       = parent[v];
                parent[v] = r;
                v         = nxt;
            end
            return r;
        endfunction

        function void merge(logic [mecc_pkg::NODE_W-1:0] a, logic [mecc_pkg::NODE_W-1:0] b);
            logic [mecc_pkg::NODE_W-1:0] ra;
            logic [mecc_pkg::NODE_W-1:0] rb;
            logic [mecc_pkg::NODE_W-1:0] t;
            ra = find_root(a);
            rb = find_root(b);
            if (ra == rb)
                return;
            if (rank_of[ra] < rank_of[rb])
            begin
                t  = ra;
                ra = rb;
                rb = t;
            end
            parent[rb] = ra;
            if (rank_of[ra] == rank_of[rb] && rank_of[ra] < mecc_pkg::RANK_MAX)
                rank_of[ra]++;
        endfunction

        function void note_edge(mecc_pkg::in_item_t e);
            mecc_pkg::out_item_t x;
            x = '0;
            x.result_edge_id = e.edge_id;
            if (e.first_of_graph)
                clear_forest();
            if (!group_open)
            begin
                group_open   = 1;
                group_weight = e.edge_weight;
            end
            else if (e.edge_weight > group_weight)
            begin
                foreach (pend_a[k])
                    merge(pend_a[k], pend_b[k]);
                pend_a.delete();
                pend_b.delete();
                group_weight = e.edge_weight;
            end
            else if (e.edge_weight < group_weight)
                x.weight_order_error = 1'b1;
            if (e.node_a < node_limit && e.node_b < node_limit)
            begin
                x.in_some_tree = (find_root(e.node_a) != find_root(e.node_b));
                if (pend_a.size() < mecc_pkg::MAX_GROUP_DEF)
                begin
                    pend_a.push_back(e.node_a);
                    pend_b.push_back(e.node_b);
                end
                else
                    x.group_overflow = 1'b1;
            end
            answers_due.push_back(x);
        endfunction

        function void check_result(mecc_pkg::out_item_t got);
            mecc_pkg::out_item_t x;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: id=%h tree=%b order=%b ovf=%b",
                             got.result_edge_id, got.in_some_tree,
                             got.weight_order_error, got.group_overflow);
                return;
            end
            x = answers_due.pop_front();
            if (got !== x)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h %b %b %b, got %h %b %b %b",
                             x.result_edge_id, x.in_some_tree, x.weight_order_error,
                             x.group_overflow, got.result_edge_id, got.in_some_tree,
                             got.weight_order_error, got.group_overflow);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mecc_pkg::PADDR_W-1:0] paddr;
    logic [mecc_pkg::PDATA_W-1:0] pwdata;
    logic [mecc_pkg::PDATA_W-1:0] prdata;
    logic pready;

    mecc_stream_if #(.payload_t(mecc_pkg::in_item_t))  in_ch ();
    mecc_stream_if #(.payload_t(mecc_pkg::out_item_t)) out_ch ();

    mst_edge_membership_check_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    edge_mst_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold_left;
    int edges_sent;
    logic [mecc_pkg::ID_W-1:0] next_id;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: check accepted results, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.payload);
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (recv_hold_left > 0)
        begin
            recv_hold_left = recv_hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_edge(mecc_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_edge(it);
        edges_sent++;
    endtask

    task automatic send_fields(int a, int b, logic [31:0] w, bit first);
        mecc_pkg::in_item_t it;
        it.node_a         = mecc_pkg::NODE_W'(a);
        it.node_b         = mecc_pkg::NODE_W'(b);
        it.edge_weight    = w;
        it.edge_id        = next_id;
        it.first_of_graph = first;
        next_id           = mecc_pkg::ID_W'($urandom);
        send_edge(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_node_count(logic [mecc_pkg::NCOUNT_W-1:0] v);
        drain();
        repeat (40) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mecc_pkg::REG_NODE_COUNT, 2'b00};
        pwdata  <= mecc_pkg::PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_node_count(v);
    endtask

    // one graph: mostly in-range endpoints in mostly nondecreasing weight groups
    task automatic send_graph(int n_edges);
        logic [31:0] w;
        int a;
        int b;
        int lim;
        lim = sb.node_limit;
        case ($urandom_range(0, 3))
            0: w = 0;
            1: w = 32'hFFFF_FFFF - $urandom_range(0, 50);
            default: w = $urandom;
        endcase
        for (int i = 0; i < n_edges; i++)
        begin
            a = $urandom_range(0, lim - 1);
            b = $urandom_range(0, lim - 1);
            if ($urandom_range(0, 99) < 8)
                a = $urandom_range(0, 1023);
            if ($urandom_range(0, 99) < 8)
                b = $urandom_range(0, 1023);
            if ($urandom_range(0, 99) < 5)
                b = a;
            send_fields(a, b, w, i == 0 || $urandom_range(0, 99) < 2);
            if ($urandom_range(0, 99) < 5)
                w = w - $urandom_range(1, 3);
            else if ($urandom_range(0, 1))
                w = w + $urandom_range(1, 1000);
        end
    endtask

    // fills the pending buffer past its depth, then closes the group
    task automatic send_big_group();
        logic [31:0] w;
        w = $urandom_range(0, 1000);
        for (int i = 0; i < mecc_pkg::MAX_GROUP_DEF + 3; i++)
            send_fields($urandom_range(0, 1023), $urandom_range(0, 1023), w, i == 0);
        send_fields($urandom_range(0, 1023), $urandom_range(0, 1023), w + 1, 1'b0);
    endtask

    logic [mecc_pkg::NCOUNT_W-1:0] counts [8] = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd16,
                                                  11'd300, 11'd5, 11'd1024};

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.payload  <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = 0;
        edges_sent     = 0;
        next_id        = '0;
        sb.clear_forest();
        sb.set_node_count(mecc_pkg::NCOUNT_W'(mecc_pkg::NCOUNT_RST));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, group deferral, self loop, weight drop
        send_fields(0, 1023, 32'd0, 1'b1);
        send_fields(1023, 0, 32'd0, 1'b0);
        send_fields(5, 5, 32'd0, 1'b0);
        send_fields(1, 2, 32'd5, 1'b0);
        send_fields(0, 1023, 32'd5, 1'b0);
        send_fields(2, 1, 32'd5, 1'b0);
        send_fields(3, 4, 32'd2, 1'b0);
        send_fields(682, 341, 32'hAAAA_5555, 1'b0);
        send_fields(1, 1023, 32'hFFFF_FFFF, 1'b0);
        next_id = 16'hFFFF;
        send_fields(4, 1022, 32'hFFFF_FFFF, 1'b0);
        send_fields(0, 0, 32'hFFFF_FFFF, 1'b1);
        write_node_count(11'd1);
        send_fields(0, 0, 32'd7, 1'b1);
        send_fields(1, 0, 32'd7, 1'b0);
        send_fields(0, 1023, 32'd8, 1'b0);
        write_node_count(11'd1024);
        send_big_group();

        for (int p = 0; p < 8; p++)
        begin
            write_node_count(counts[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int g = 0; edges_sent < 290 + 60 * (p + 1); g++)
            begin
                if (g == 2 && p == 2)
                    recv_hold_left = 400;
                if (g == 3 && p == 5)
                    drain();
                send_graph($urandom_range(1, 20));
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.answers_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== mst_edge_membership_check_core.f =====
hw/rtl/mecc_pkg.sv
hw/rtl/mecc_stream_if.sv
hw/rtl/mecc_cfg.sv
hw/rtl/mecc_forest.sv
hw/rtl/mst_edge_membership_check_core.sv
tb/sv/mst_edge_membership_check_core_tb.sv
